@@ sv/dequ_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dequ_pkg: shared definitions for the double-ended queue unit
// Operation codes, status codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package dequ_pkg;

	// field widths fixed by the request format
	localparam int ModeW   = 3;
	localparam int ValueW  = 32;
	localparam int IndexW  = 6;
	localparam int DataW   = 32;
	localparam int StatusW = 2;
	localparam int CountW  = 7;

	// operation codes
	localparam logic [ModeW-1:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [ModeW-1:0] MODE_POP_BACK   = 3'd2;
	localparam logic [ModeW-1:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [ModeW-1:0] MODE_READ       = 3'd4;

	// status codes
	localparam logic [StatusW-1:0] ST_OK    = 2'd0;
	localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
	localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;   // take the request on the ports this cycle
		logic respond;  // result is presented this cycle
	} dequ_cmd_t;

endpackage

@@ sv/dequ_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dequ_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module dequ_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write takes priority, read data lands in the next cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ sv/dequ_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dequ_datapath: pointers, slot arithmetic and element store
// Decodes the request, updates back position and count, drives the store.
// ----------------------------------------------------------------------------
module dequ_datapath
	import dequ_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dequ_cmd_t           cmd,
	input  logic [ModeW-1:0]    mode,
	input  logic [ValueW-1:0]   value,
	input  logic [IndexW-1:0]   index,
	output logic [DataW-1:0]    data,
	output logic [StatusW-1:0]  status,
	output logic [CountW-1:0]   count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = CW + IndexW;

	logic [AW-1:0]         back_q;
	logic [CW-1:0]         count_q;
	logic [StatusW-1:0]    status_q;
	logic                  rd_sel_q;

	logic                  full;
	logic                  empty;
	logic                  idx_ok;
	logic [AW-1:0]         back_dec;
	logic [AW-1:0]         back_inc;
	logic [AW-1:0]         offset;
	logic [AW:0]           slot_sum;
	logic [AW-1:0]         slot;
	logic [AW-1:0]         addr;
	logic                  we;
	logic                  re;
	logic [AW-1:0]         back_d;
	logic [CW-1:0]         count_d;
	logic [StatusW-1:0]    status_d;
	logic                  rd_sel_d;
	logic [ELEM_WIDTH-1:0] rdata;

	// occupancy checks
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign idx_ok = (WW'(index) < WW'(count_q));

	// back pointer neighbors, wrapping at the store depth
	assign back_dec = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);
	assign back_inc = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + AW'(1);

	// slot of element at offset from the back, one compare and subtract
	assign slot_sum = {1'b0, back_q} + {1'b0, offset};
	assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ?
		AW'(slot_sum - (AW+1)'(DEPTH)) : AW'(slot_sum);

	// request decode
	always_comb begin
		offset   = '0;
		addr     = slot;
		we       = 1'b0;
		re       = 1'b0;
		back_d   = back_q;
		count_d  = count_q;
		status_d = ST_OK;
		rd_sel_d = 1'b0;
		unique case (mode)
			MODE_PUSH_BACK: begin
				addr = back_dec;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					we      = 1'b1;
					back_d  = back_dec;
					count_d = count_q + CW'(1);
				end
			end
			MODE_PUSH_FRONT: begin
				offset = AW'(count_q);
				if (full) begin
					status_d = ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			MODE_POP_BACK: begin
				addr = back_q;
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					re       = 1'b1;
					rd_sel_d = 1'b1;
					back_d   = back_inc;
					count_d  = count_q - CW'(1);
				end
			end
			MODE_POP_FRONT: begin
				offset = AW'(count_q - CW'(1));
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					re       = 1'b1;
					rd_sel_d = 1'b1;
					count_d  = count_q - CW'(1);
				end
			end
			MODE_READ: begin
				offset = AW'(index);
				if (!idx_ok) begin
					status_d = ST_EMPTY;
				end else begin
					re       = 1'b1;
					rd_sel_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	// result status held for the response cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q <= status_d;
			rd_sel_q <= rd_sel_d;
		end
	end

	// element store
	dequ_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.accept & we),
		.re    (cmd.accept & re),
		.addr  (addr),
		.wdata (ELEM_WIDTH'(value)),
		.rdata (rdata)
	);

	// result ports, quiet outside the response cycle
	assign data   = (cmd.respond && rd_sel_q) ? DataW'(rdata) : '0;
	assign status = cmd.respond ? status_q : '0;
	assign count  = cmd.respond ? CountW'(count_q) : '0;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_back_bound: assert property (@(posedge clk) disable iff (!arst_n)
		back_q <= AW'(DEPTH - 1))
		else $error("back position outside store");

	a_read_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.respond && rd_sel_q) |-> (status_q == ST_OK))
		else $error("read data shown with an error status");

endmodule

@@ sv/dequ_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dequ_ctrl: request sequencer
// Accepts a request, then presents its result on the following cycle.
// ----------------------------------------------------------------------------
module dequ_ctrl
	import dequ_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output dequ_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic state_q;
	logic state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// handshake and datapath commands
	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_RESP);
	assign cmd.accept  = start && !busy;
	assign cmd.respond = done;

	a_accept_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> done)
		else $error("accepted request without a result");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.accept))
		else $error("result without an accepted request");

endmodule

@@ sv/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue
// Push and pop at either end, read by index from the back, circular store.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The store is written
// or read at the accepting edge, and the result (data, status, count) is shown
// with done high for exactly the next cycle, during which busy is high, so a
// new request is taken only after the previous result has been shown.
// The receiver cannot stall: a result must be captured while done is high.
// Status 1 marks a pop or read on empty queue or index out of range, status 2
// a push refused because the queue is full. Result ports read zero outside
// the done cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
	import dequ_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [ModeW-1:0]   mode,
	input  logic [ValueW-1:0]  value,
	input  logic [IndexW-1:0]  index,
	output logic               done,
	output logic [DataW-1:0]   data,
	output logic [StatusW-1:0] status,
	output logic [CountW-1:0]  count
);

	dequ_cmd_t cmd;

	// sequencer
	dequ_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// pointers and store
	dequ_datapath #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.mode   (mode),
		.value  (value),
		.index  (index),
		.data   (data),
		.status (status),
		.count  (count)
	);

endmodule

@@ sim/deque_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker: result checker for the double-ended queue unit
// Watches the request and result ports, keeps a shadow copy of the queue,
// predicts each result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module deque_checker
	import dequ_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [ModeW-1:0]   mode,
	input  logic [ValueW-1:0]  value,
	input  logic [IndexW-1:0]  index,
	input  logic               done,
	input  logic [DataW-1:0]   data,
	input  logic [StatusW-1:0] status,
	input  logic [CountW-1:0]  count,
	output int                 pending,
	output int                 failures
);

	localparam logic [DataW-1:0] ElemMask = {DataW{1'b1}} >> (DataW - ELEM_WIDTH);

	typedef struct packed {
		logic [DataW-1:0]   data;
		logic [StatusW-1:0] status;
		logic [CountW-1:0]  count;
	} deque_result_t;

	// shadow queue: element i sits at slot (back_slot + i) mod DEPTH
	logic [DataW-1:0] shadow_store [DEPTH];
	int               back_slot;
	int               held;
	deque_result_t    expected_results [$];
	int               mismatch_total;

	// apply one request to the shadow queue and return its result
	task automatic apply_request(
		input  logic [ModeW-1:0]  op,
		input  logic [ValueW-1:0] val,
		input  logic [IndexW-1:0] idx,
		output deque_result_t     res
	);
		logic [DataW-1:0] elem;
		elem       = val & ElemMask;
		res.data   = '0;
		res.status = ST_OK;
		case (op)
			MODE_PUSH_BACK: begin
				if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					back_slot = (back_slot + DEPTH - 1) % DEPTH;
					shadow_store[back_slot] = elem;
					held++;
				end
			end
			MODE_PUSH_FRONT: begin
				if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_store[(back_slot + held) % DEPTH] = elem;
					held++;
				end
			end
			MODE_POP_BACK: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data  = shadow_store[back_slot];
					back_slot = (back_slot + 1) % DEPTH;
					held--;
				end
			end
			MODE_POP_FRONT: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data = shadow_store[(back_slot + held - 1) % DEPTH];
					held--;
				end
			end
			MODE_READ: begin
				if (int'(idx) >= held) begin
					res.status = ST_EMPTY;
				end else begin
					res.data = shadow_store[(back_slot + int'(idx)) % DEPTH];
				end
			end
			default: begin
				// unused codes leave the queue alone
			end
		endcase
		res.count = CountW'(held);
	endtask

	always @(posedge clk) begin
		deque_result_t want;
		deque_result_t fresh;
		if (!arst_n) begin
			back_slot = 0;
			held      = 0;
			expected_results.delete();
		end else begin
			// compare an arriving result with the oldest prediction
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					mismatch_total++;
				end else begin
					want = expected_results.pop_front();
					if (data !== want.data) begin
						$error("data mismatch: expected %h, actual %h", want.data, data);
						mismatch_total++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
						mismatch_total++;
					end
					if (count !== want.count) begin
						$error("count mismatch: expected %0d, actual %0d",
							want.count, count);
						mismatch_total++;
					end
				end
			end
			// predict the result of a request taken at this edge
			if (start && !busy) begin
				apply_request(mode, value, index, fresh);
				expected_results.push_back(fresh);
			end
		end
		pending  <= expected_results.size();
		failures <= mismatch_total;
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the double-ended queue unit
// Drives directed corner requests, then random fill, drain and mixed phases
// in bursts with random gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import dequ_pkg::*;

	localparam int Depth       = 64;
	localparam int ElemWidth   = 32;
	localparam int RandomItems = 1800;
	localparam int DrainLimit  = 200;

	typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_kind_t;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic [ModeW-1:0]   mode   = '0;
	logic [ValueW-1:0]  value  = '0;
	logic [IndexW-1:0]  index  = '0;
	logic               busy;
	logic               done;
	logic [DataW-1:0]   data;
	logic [StatusW-1:0] status;
	logic [CountW-1:0]  count;
	int                 pending;
	int                 failures;
	int                 burst_left = 0;

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	double_ended_queue_unit #(
		.DEPTH      (Depth),
		.ELEM_WIDTH (ElemWidth)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.mode   (mode),
		.value  (value),
		.index  (index),
		.done   (done),
		.data   (data),
		.status (status),
		.count  (count)
	);

	deque_checker #(
		.DEPTH      (Depth),
		.ELEM_WIDTH (ElemWidth)
	) checker_inst (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.value    (value),
		.index    (index),
		.done     (done),
		.data     (data),
		.status   (status),
		.count    (count),
		.pending  (pending),
		.failures (failures)
	);

	// present one request and hold it until the block takes it
	task automatic send_request(
		input logic [ModeW-1:0]  op,
		input logic [ValueW-1:0] val,
		input logic [IndexW-1:0] idx
	);
		start <= 1'b1;
		mode  <= op;
		value <= val;
		index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// stop sending until every outstanding result has come back
	task automatic pause_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// bursts of back-to-back requests separated by random gaps
	task automatic sender_idle();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// one random request shaped by the current phase
	task automatic random_request(input segment_kind_t seg, output bit counted);
		int                roll;
		logic [ModeW-1:0]  op;
		logic [ModeW-1:0]  push_op;
		logic [ModeW-1:0]  pop_op;
		logic [ValueW-1:0] val;
		logic [IndexW-1:0] idx;
		roll    = $urandom_range(0, 99);
		push_op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
		pop_op  = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
		if (roll < 2) begin
			op = ModeW'($urandom_range(int'(MODE_READ) + 1, (1 << ModeW) - 1));
		end else begin
			case (seg)
				SEG_FILL:  op = (roll < 82) ? push_op : (roll < 92) ? MODE_READ : pop_op;
				SEG_DRAIN: op = (roll < 82) ? pop_op : (roll < 90) ? MODE_READ : push_op;
				default:   op = (roll < 35) ? push_op : (roll < 70) ? pop_op : MODE_READ;
			endcase
		end
		case ($urandom_range(0, 9))
			0:       val = '0;
			1:       val = '1;
			default: val = $urandom;
		endcase
		idx = $urandom_range(0, 1) ? IndexW'($urandom_range(0, (1 << IndexW) - 1))
			: IndexW'($urandom_range(0, 7));
		counted = (op <= MODE_READ);
		send_request(op, val, idx);
	endtask

	// run limit
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int            sent;
		int            seg_left;
		bit            counted;
		segment_kind_t seg;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: pops and read report empty
		send_request(MODE_POP_BACK, 32'hFFFF_FFFF, '0);
		send_request(MODE_POP_FRONT, '0, '0);
		send_request(MODE_READ, '0, '0);
		// extreme values at both ends, back pointer wraps below zero
		send_request(MODE_PUSH_BACK, 32'hFFFF_FFFF, '1);
		send_request(MODE_PUSH_FRONT, 32'h0000_0000, '0);
		send_request(MODE_PUSH_BACK, 32'hA5A5_A5A5, '0);
		send_request(MODE_PUSH_FRONT, 32'h5A5A_5A5A, '0);
		// reads in range, then at and beyond the count
		for (int i = 0; i < 5; i++) send_request(MODE_READ, $urandom, IndexW'(i));
		send_request(MODE_READ, '0, '1);
		// unused codes are ignored
		for (int m = int'(MODE_READ) + 1; m < (1 << ModeW); m++)
			send_request(ModeW'(m), $urandom, IndexW'($urandom));
		// empty it from both ends, then pop once more
		send_request(MODE_POP_FRONT, '0, '0);
		send_request(MODE_POP_BACK, '0, '0);
		send_request(MODE_POP_FRONT, '0, '0);
		send_request(MODE_POP_BACK, '0, '0);
		send_request(MODE_POP_BACK, '0, '0);
		// single element pushed at the front leaves from the back
		send_request(MODE_PUSH_FRONT, 32'h8000_0001, '0);
		send_request(MODE_POP_BACK, '0, '0);
		pause_until_drained();

		// random phases that fill to full, drain to empty, or mix
		sent     = 0;
		seg_left = 0;
		seg      = SEG_MIXED;
		while (sent < RandomItems) begin
			if (seg_left == 0) begin
				seg      = segment_kind_t'($urandom_range(0, 2));
				seg_left = $urandom_range(40, 140);
				if ($urandom_range(0, 4) == 0) pause_until_drained();
			end
			sender_idle();
			random_request(seg, counted);
			if (counted) sent++;
			seg_left--;
		end

		// wait out the last results, then a few quiet cycles
		start <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < DrainLimit && pending != 0; i++) @(posedge clk);
		repeat (4) @(posedge clk);
		if (pending != 0) $error("%0d expected results never arrived", pending);
		if (failures == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
